>>> rtl/crt_pkg.sv
`default_nettype none

package crt_pkg;

    // Default segment subdivision and coordinate precision
    localparam int STEPS_DEF      = 20;
    localparam int COORD_BITS_DEF = 16;

    // Field widths on the stream ports
    localparam int COORD_W   = 16;
    localparam int OUT_W     = 18;
    localparam int IN_DATA_W = 32;
    localparam int OUT_DATA_W = 40;

    // Signed width of the forward-difference numerators (covers STEPS up to 31)
    localparam int NUM_W = 28;
    // Width of the integer part held by the quotient/remainder accumulators
    localparam int QW = 24;

endpackage : crt_pkg

`default_nettype wire

>>> rtl/crt_div.sv
`default_nettype none

// Divider by a fixed divisor using reciprocal multiplication.
// Returns the floor quotient and the non-negative remainder of a signed value.
// The product with the scaled reciprocal gives a quotient that is low by at most
// one; the remainder is formed next and one compare and subtract fixes both.
// Result is valid with o_done after the multiply, remainder and correct phases.
module crt_div import crt_pkg::*; #(
    parameter int K_VAL = 2 * STEPS_DEF * STEPS_DEF * STEPS_DEF,
    parameter int KW    = $clog2(2 * STEPS_DEF * STEPS_DEF * STEPS_DEF + 1)
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_start,
    input  wire logic signed [NUM_W-1:0] i_num,
    output logic                         o_done,
    output logic [QW-1:0]                o_quo,
    output logic [KW-1:0]                o_rem
);

    // Reciprocal of the divisor scaled by 2^NUM_W
    localparam longint RECIP = (longint'(1) << NUM_W) / longint'(K_VAL);
    localparam logic [NUM_W-1:0] M_RECIP = NUM_W'(RECIP);
    localparam logic [NUM_W-1:0] K_WIDE  = NUM_W'(K_VAL);
    localparam logic [KW:0]      K_EXT   = (KW + 1)'(K_VAL);
    localparam logic [KW-1:0]    K_REM   = KW'(K_VAL);

    typedef enum logic [1:0] {PH_IDLE, PH_MUL, PH_REM, PH_FIX} t_phase;

    t_phase             r_phase;
    logic               r_done;
    logic               r_neg;
    logic [NUM_W-1:0]   r_mag;
    logic [NUM_W-1:0]   r_quo;
    logic [KW:0]        r_rem;

    logic [NUM_W-1:0]   abs_num;
    logic [2*NUM_W-1:0] prod;
    logic [NUM_W-1:0]   back;
    logic [NUM_W-1:0]   rem_wide;
    logic [QW-1:0]      quo_mag;
    logic [KW-1:0]      rem_fin;
    logic               rem_nz;

    // Magnitude, quotient estimate and estimated remainder
    always_comb begin
        abs_num  = i_num[NUM_W-1] ? NUM_W'(-i_num) : NUM_W'(i_num);
        prod     = r_mag * M_RECIP;
        back     = r_quo * K_WIDE;
        rem_wide = r_mag - back;
    end

    // Sequencer: capture, multiply, remainder, correct
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_done  <= 1'b0;
        end else begin
            case (r_phase)
                PH_IDLE: begin
                    r_done <= 1'b0;
                    if (i_start) begin
                        r_mag   <= abs_num;
                        r_neg   <= i_num[NUM_W-1];
                        r_phase <= PH_MUL;
                    end
                end
                PH_MUL: begin
                    r_quo   <= prod[2*NUM_W-1:NUM_W];
                    r_phase <= PH_REM;
                end
                PH_REM: begin
                    r_rem   <= rem_wide[KW:0];
                    r_phase <= PH_FIX;
                end
                default: begin
                    // estimate one short: remainder still at or above the divisor
                    if (r_rem >= K_EXT) begin
                        r_rem <= r_rem - K_EXT;
                        r_quo <= r_quo + NUM_W'(1);
                    end
                    r_done  <= 1'b1;
                    r_phase <= PH_IDLE;
                end
            endcase
        end
    end

    // Fold the sign back in, rounding toward minus infinity
    always_comb begin
        quo_mag = r_quo[QW-1:0];
        rem_fin = r_rem[KW-1:0];
        rem_nz  = (rem_fin != '0);
        if (r_neg && rem_nz) begin
            o_quo = ~quo_mag;
            o_rem = K_REM - rem_fin;
        end else if (r_neg) begin
            o_quo = -quo_mag;
            o_rem = rem_fin;
        end else begin
            o_quo = quo_mag;
            o_rem = rem_fin;
        end
    end

    assign o_done = r_done;

endmodule : crt_div

`default_nettype wire

>>> rtl/catmull_rom_curve_tessellator.sv
`default_nettype none

// Uniform Catmull-Rom tessellator.
// Slave stream: one control point per transaction, x in tdata[15:0], y in
// tdata[31:16], tlast marks the final point of a curve. Master stream: one
// curve sample per transaction, x in tdata[17:0] and y in tdata[35:18] (signed),
// tuser is the pen-down flag (0 = move at curve start), tlast marks the last
// sample caused by the input point.
// The first two points of a curve produce nothing, except that a tlast second
// point produces STEPS+1 samples of the only segment. Each later point produces
// STEPS+1 samples of the previous segment, and a tlast point adds STEPS+1 more
// for the closing segment. A single-point curve produces nothing.
// Per segment the shared divider runs six divisions by 2*STEPS^3 (forward
// differences for x and y) one after another during setup; then one sample
// per cycle is stepped out by forward differencing while the receiver accepts.
// A point holds the block through the setup and stepping of its segment, and a
// closing point through both of its segments. tready is high only while the
// block waits for a point. Output is a register: a stalled receiver holds the
// sample and pauses stepping, and a new point may be taken while the final
// sample still waits. Synchronous reset empties the curve history and the
// output register.
module catmull_rom_curve_tessellator import crt_pkg::*; #(
    parameter int STEPS      = STEPS_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,  // point_x, point_y
    input  wire logic                  s_axis_tlast,  // end_of_curve
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0]      m_axis_tdata,  // sample_x, sample_y, zero pad
    output logic                       m_axis_tuser,  // pen_down
    output logic                       m_axis_tlast   // last_sample
);

    localparam int K  = 2 * STEPS * STEPS * STEPS;
    localparam int KW = $clog2(K + 1);
    localparam int SW = $clog2(STEPS + 1);
    localparam logic [SW-1:0]          STEP_LAST = SW'(STEPS);
    localparam logic [KW:0]            K_EXT     = (KW + 1)'(K);
    localparam logic signed [NUM_W-1:0] S_SQ     = NUM_W'(STEPS * STEPS);
    localparam logic signed [NUM_W-1:0] S_ONE    = NUM_W'(STEPS);

    typedef enum logic [1:0] {S_IDLE, S_SETUP, S_WAIT, S_EMIT} t_state;
    typedef enum logic [1:0] {TERM_D1, TERM_D2, TERM_D3} t_term;

    // Value held as floor quotient and remainder by K
    typedef struct packed {
        logic [QW-1:0] q;
        logic [KW-1:0] r;
    } t_dm;

    function automatic t_dm dm_add(input t_dm a, input t_dm b);
        logic [KW:0] rs;
        logic [KW:0] rk;
        t_dm         res;
        rs = {1'b0, a.r} + {1'b0, b.r};
        rk = rs - K_EXT;
        if (rs >= K_EXT) begin
            res.r = rk[KW-1:0];
            res.q = a.q + b.q + QW'(1);
        end else begin
            res.r = rs[KW-1:0];
            res.q = a.q + b.q;
        end
        return res;
    endfunction

    t_state              r_state;
    logic [1:0]          r_seen;
    logic [COORD_W-1:0]  r_win_x [3];
    logic [COORD_W-1:0]  r_win_y [3];
    logic [COORD_W-1:0]  r_seg_x [4];
    logic [COORD_W-1:0]  r_seg_y [4];
    logic                r_start;
    logic                r_more;
    logic                r_lane;
    t_term               r_term;
    logic [SW-1:0]       r_step;
    logic                r_div_start;
    t_dm                 r_p  [2];
    t_dm                 r_d1 [2];
    t_dm                 r_d2 [2];
    t_dm                 r_d3 [2];
    logic                r_m_valid;
    logic [OUT_DATA_W-1:0] r_m_data;
    logic                r_m_user;
    logic                r_m_last;

    logic                in_acc;
    logic                emit;
    logic [COORD_W-1:0]  new_x;
    logic [COORD_W-1:0]  new_y;
    logic signed [NUM_W-1:0] a0, a1, a2, a3;
    logic signed [NUM_W-1:0] v_b, v_c, v_d, v_bb, v_cc, v_n1, v_n2, v_n3;
    logic signed [NUM_W-1:0] div_num;
    logic                div_done;
    logic [QW-1:0]       div_quo;
    logic [KW-1:0]       div_rem;
    t_dm                 div_res;
    t_dm                 n_p  [2];
    t_dm                 n_d1 [2];
    t_dm                 n_d2 [2];
    logic [QW-1:0]       coord [2];

    assign in_acc = s_axis_tvalid && s_axis_tready;
    assign emit   = (r_state == S_EMIT) && (!r_m_valid || m_axis_tready);
    assign new_x  = COORD_W'(s_axis_tdata[COORD_BITS-1:0]);
    assign new_y  = COORD_W'(s_axis_tdata[COORD_W+COORD_BITS-1:COORD_W]);

    // Forward-difference numerators of the selected coordinate
    always_comb begin
        a0 = $signed(NUM_W'(r_lane ? r_seg_y[0] : r_seg_x[0]));
        a1 = $signed(NUM_W'(r_lane ? r_seg_y[1] : r_seg_x[1]));
        a2 = $signed(NUM_W'(r_lane ? r_seg_y[2] : r_seg_x[2]));
        a3 = $signed(NUM_W'(r_lane ? r_seg_y[3] : r_seg_x[3]));
        v_b  = a2 - a0;
        v_c  = (a0 <<< 1) - (a1 <<< 2) - a1 + (a2 <<< 2) - a3;
        v_d  = a3 - a0 + ((a1 - a2) <<< 1) + (a1 - a2);
        v_bb = v_b * S_SQ;
        v_cc = v_c * S_ONE;
        v_n1 = v_bb + v_cc + v_d;
        v_n3 = (v_d <<< 2) + (v_d <<< 1);
        v_n2 = (v_cc <<< 1) + v_n3;
        case (r_term)
            TERM_D1: div_num = v_n1;
            TERM_D2: div_num = v_n2;
            default: div_num = v_n3;
        endcase
    end

    crt_div #(
        .K_VAL (K),
        .KW    (KW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_div_start),
        .i_num   (div_num),
        .o_done  (div_done),
        .o_quo   (div_quo),
        .o_rem   (div_rem)
    );

    assign div_res = '{q: div_quo, r: div_rem};

    // Next sample per lane, and truncation toward zero of the current one
    always_comb begin
        for (int l = 0; l < 2; l++) begin
            n_p[l]  = dm_add(r_p[l], r_d1[l]);
            n_d1[l] = dm_add(r_d1[l], r_d2[l]);
            n_d2[l] = dm_add(r_d2[l], r_d3[l]);
            coord[l] = (r_p[l].q[QW-1] && (r_p[l].r != '0)) ? r_p[l].q + QW'(1)
                                                             : r_p[l].q;
        end
    end

    // Sequencer, curve history and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_seen      <= '0;
            r_m_valid   <= 1'b0;
            r_div_start <= 1'b0;
        end else begin
            // one divider start per setup cycle
            r_div_start <= (r_state == S_SETUP);

            if (emit) begin
                r_m_valid <= 1'b1;
                r_m_data  <= {(OUT_DATA_W - 2 * OUT_W)'(0), coord[1][OUT_W-1:0],
                              coord[0][OUT_W-1:0]};
                r_m_user  <= !(r_start && (r_step == '0));
                r_m_last  <= (r_step == STEP_LAST) && !r_more;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_win_x[0] <= r_win_x[1];
                        r_win_x[1] <= r_win_x[2];
                        r_win_x[2] <= new_x;
                        r_win_y[0] <= r_win_y[1];
                        r_win_y[1] <= r_win_y[2];
                        r_win_y[2] <= new_y;
                        if (s_axis_tlast) begin
                            r_seen <= '0;
                        end else if (r_seen != 2'd3) begin
                            r_seen <= r_seen + 2'd1;
                        end
                        r_lane <= 1'b0;
                        r_term <= TERM_D1;
                        if (r_seen == 2'd1 && s_axis_tlast) begin
                            // only segment of a two-point curve
                            r_seg_x[0] <= r_win_x[2];
                            r_seg_x[1] <= r_win_x[2];
                            r_seg_x[2] <= new_x;
                            r_seg_x[3] <= new_x;
                            r_seg_y[0] <= r_win_y[2];
                            r_seg_y[1] <= r_win_y[2];
                            r_seg_y[2] <= new_y;
                            r_seg_y[3] <= new_y;
                            r_start    <= 1'b1;
                            r_more     <= 1'b0;
                            r_state    <= S_SETUP;
                        end else if (r_seen >= 2'd2) begin
                            // first segment duplicates its leading point, later segments use the window
                            r_seg_x[0] <= (r_seen == 2'd2) ? r_win_x[1] : r_win_x[0];
                            r_seg_x[1] <= r_win_x[1];
                            r_seg_x[2] <= r_win_x[2];
                            r_seg_x[3] <= new_x;
                            r_seg_y[0] <= (r_seen == 2'd2) ? r_win_y[1] : r_win_y[0];
                            r_seg_y[1] <= r_win_y[1];
                            r_seg_y[2] <= r_win_y[2];
                            r_seg_y[3] <= new_y;
                            r_start    <= (r_seen == 2'd2);
                            r_more     <= s_axis_tlast;
                            r_state    <= S_SETUP;
                        end
                    end
                end

                S_SETUP: begin
                    r_state <= S_WAIT;
                end

                S_WAIT: begin
                    if (div_done) begin
                        case (r_term)
                            TERM_D1: r_d1[r_lane] <= div_res;
                            TERM_D2: r_d2[r_lane] <= div_res;
                            default: r_d3[r_lane] <= div_res;
                        endcase
                        case (r_term)
                            TERM_D1: begin
                                r_term  <= TERM_D2;
                                r_state <= S_SETUP;
                            end
                            TERM_D2: begin
                                r_term  <= TERM_D3;
                                r_state <= S_SETUP;
                            end
                            default: begin
                                r_term <= TERM_D1;
                                if (r_lane) begin
                                    // segment start sits exactly on the second point
                                    r_p[0]  <= '{q: QW'(r_seg_x[1]), r: '0};
                                    r_p[1]  <= '{q: QW'(r_seg_y[1]), r: '0};
                                    r_step  <= '0;
                                    r_state <= S_EMIT;
                                end else begin
                                    r_lane  <= 1'b1;
                                    r_state <= S_SETUP;
                                end
                            end
                        endcase
                    end
                end

                S_EMIT: begin
                    if (emit) begin
                        for (int l = 0; l < 2; l++) begin
                            r_p[l]  <= n_p[l];
                            r_d1[l] <= n_d1[l];
                            r_d2[l] <= n_d2[l];
                        end
                        r_step <= r_step + SW'(1);
                        if (r_step == STEP_LAST) begin
                            if (r_more) begin
                                // closing segment: end point duplicated
                                r_seg_x[0] <= r_win_x[0];
                                r_seg_x[1] <= r_win_x[1];
                                r_seg_x[2] <= r_win_x[2];
                                r_seg_x[3] <= r_win_x[2];
                                r_seg_y[0] <= r_win_y[0];
                                r_seg_y[1] <= r_win_y[1];
                                r_seg_y[2] <= r_win_y[2];
                                r_seg_y[3] <= r_win_y[2];
                                r_start    <= 1'b0;
                                r_more     <= 1'b0;
                                r_lane     <= 1'b0;
                                r_term     <= TERM_D1;
                                r_state    <= S_SETUP;
                            end else begin
                                r_state <= S_IDLE;
                            end
                        end
                    end
                end

                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign m_axis_tuser  = r_m_user;
    assign m_axis_tlast  = r_m_last;

    // Divider results arrive only while the sequencer waits for them
    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == S_WAIT))
        else $error("divider finished outside of wait state");

    // Sample counter never runs past the segment end
    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> (r_step <= STEP_LAST))
        else $error("sample counter out of range");

    // Final sample of a point is flagged and returns the block to idle
    a_tail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit && (r_step == STEP_LAST) && !r_more) |=>
            ((r_state == S_IDLE) && m_axis_tvalid && m_axis_tlast))
        else $error("last sample not flagged or block not idle");

endmodule : catmull_rom_curve_tessellator

`default_nettype wire

>>> tb/sv/tb.sv
`timescale 1ns / 100ps

module tb;
    import crt_pkg::*;

    localparam int RANDOM_ITEMS   = 255;
    localparam int MAX_GAP        = 13;
    // room for two segments to drain, with margin
    localparam int DRAIN_CYCLES   = 500;
    localparam int TIMEOUT_CYCLES = 1_500_000;
    localparam int MAX_REPORTS    = 60;
    localparam longint COORD_MASK = (64'd1 << COORD_BITS_DEF) - 1;

    // one expected curve sample
    typedef struct {
        logic signed [OUT_W-1:0] x;
        logic signed [OUT_W-1:0] y;
        logic                    pen;
        logic                    last;
    } t_sample;

    // directed row; flat marks a transaction whose samples all sit on the point itself
    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic               eoc;
        logic               flat;
    } t_point_row;

    // how the coordinates of one random curve are spread
    typedef enum int {SPREAD_FULL, SPREAD_NEAR, SPREAD_EDGE} t_spread;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;   // point_x, point_y
    logic                  s_axis_tlast;   // end_of_curve
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;   // sample_x, sample_y, zero pad
    logic                  m_axis_tuser;   // pen_down
    logic                  m_axis_tlast;   // last_sample

    t_sample            pending_samples[$];
    logic [COORD_W-1:0] win_x[3];
    logic [COORD_W-1:0] win_y[3];
    int                 points_in_curve;
    int                 mismatch_count;
    int                 cycle_count;
    logic               no_stall;

    t_point_row directed_rows[22] = '{
        // constant curves at both extremes: every sample equals the point
        '{16'd0,     16'd0,     1'b0, 1'b0},
        '{16'd0,     16'd0,     1'b1, 1'b1},
        '{16'hFFFF,  16'hFFFF,  1'b0, 1'b0},
        '{16'hFFFF,  16'hFFFF,  1'b1, 1'b1},
        // single point curve emits nothing
        '{16'd1234,  16'd4321,  1'b1, 1'b1},
        // three points, full swing: overshoot below zero and past full scale
        '{16'd0,     16'hFFFF,  1'b0, 1'b0},
        '{16'hFFFF,  16'd0,     1'b0, 1'b0},
        '{16'd0,     16'hFFFF,  1'b1, 1'b0},
        // zigzag with interior segments
        '{16'hFFFF,  16'd0,     1'b0, 1'b0},
        '{16'd0,     16'hFFFF,  1'b0, 1'b0},
        '{16'hFFFF,  16'd0,     1'b0, 1'b0},
        '{16'd0,     16'hFFFF,  1'b0, 1'b0},
        '{16'hFFFF,  16'hFFFF,  1'b1, 1'b0},
        // two point curve, not constant
        '{16'd100,   16'd200,   1'b0, 1'b0},
        '{16'd300,   16'd50,    1'b1, 1'b0},
        // longer ordinary curve
        '{16'd10,    16'd20,    1'b0, 1'b0},
        '{16'd40,    16'd80,    1'b0, 1'b0},
        '{16'd90,    16'd30,    1'b0, 1'b0},
        '{16'd120,   16'd160,   1'b0, 1'b0},
        '{16'd200,   16'd10,    1'b0, 1'b0},
        '{16'd5,     16'd5,     1'b1, 1'b0},
        // single point right after a closed curve
        '{16'd7,     16'd7,     1'b1, 1'b1}
    };

    catmull_rom_curve_tessellator uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // 50 MHz clock
    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // one spline coordinate, exact integer form, quotient truncated toward zero
    function automatic longint spline_coord(longint q0, longint q1, longint q2, longint q3,
                                            longint s);
        longint n, b, c, d, num;
        n   = STEPS_DEF;
        b   = q2 - q0;
        c   = 2 * q0 - 5 * q1 + 4 * q2 - q3;
        d   = -q0 + 3 * q1 - 3 * q2 + q3;
        num = 2 * n * n * n * q1 + n * n * b * s + n * c * s * s + d * s * s * s;
        return num / (2 * n * n * n);
    endfunction

    // queue the STEPS+1 samples of one segment
    function automatic void add_segment(longint x0, longint x1, longint x2, longint x3,
                                        longint y0, longint y1, longint y2, longint y3,
                                        logic curve_start);
        t_sample smp;
        longint  cx, cy;
        for (int s = 0; s <= STEPS_DEF; s++) begin
            cx       = spline_coord(x0, x1, x2, x3, s);
            cy       = spline_coord(y0, y1, y2, y3, s);
            smp.x    = cx[OUT_W-1:0];
            smp.y    = cy[OUT_W-1:0];
            smp.pen  = !(curve_start && s == 0);
            smp.last = 1'b0;
            pending_samples = {pending_samples, smp};
        end
    endfunction

    // expected samples for one accepted control point, then advance the window
    function automatic void predict_point(logic [COORD_W-1:0] px, logic [COORD_W-1:0] py,
                                          logic eoc);
        longint nx, ny;
        int     first_idx;
        nx        = longint'(px) & COORD_MASK;
        ny        = longint'(py) & COORD_MASK;
        first_idx = pending_samples.size();

        if (points_in_curve == 1) begin
            // only segment: ends duplicated on both sides
            if (eoc)
                add_segment(win_x[2], win_x[2], nx, nx, win_y[2], win_y[2], ny, ny, 1'b1);
        end else if (points_in_curve >= 2) begin
            if (points_in_curve == 2)
                add_segment(win_x[1], win_x[1], win_x[2], nx,
                            win_y[1], win_y[1], win_y[2], ny, 1'b1);
            else
                add_segment(win_x[0], win_x[1], win_x[2], nx,
                            win_y[0], win_y[1], win_y[2], ny, 1'b0);
            // closing segment flushed by the final point
            if (eoc)
                add_segment(win_x[1], win_x[2], nx, nx, win_y[1], win_y[2], ny, ny, 1'b0);
        end

        if (pending_samples.size() > first_idx)
            pending_samples[pending_samples.size()-1].last = 1'b1;

        win_x[0] = win_x[1];
        win_x[1] = win_x[2];
        win_x[2] = nx[COORD_W-1:0];
        win_y[0] = win_y[1];
        win_y[1] = win_y[2];
        win_y[2] = ny[COORD_W-1:0];

        if (eoc)
            points_in_curve = 0;
        else if (points_in_curve < 3)
            points_in_curve++;
    endfunction

    function automatic logic [COORD_W-1:0] next_coord(t_spread spread,
                                                      logic [COORD_W-1:0] prev);
        int v;
        case (spread)
            SPREAD_FULL: begin
                return COORD_W'($urandom_range(0, 65535));
            end
            SPREAD_NEAR: begin
                v = int'(prev) + int'($urandom_range(0, 400)) - 200;
                if (v < 0)
                    v = 0;
                if (v > 65535)
                    v = 65535;
                return COORD_W'(v);
            end
            default: begin
                case ($urandom_range(0, 2))
                    0: return '0;
                    1: return '1;
                    default: return COORD_W'($urandom);
                endcase
            end
        endcase
    endfunction

    task automatic flag_error(input string what, input longint want, input longint got);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("%0t ns %s: expected %0d, actual %0d", $time, what, want, got);
    endtask

    // drive one point after a gap and wait for the transaction
    task automatic send_point(input logic [COORD_W-1:0] px, input logic [COORD_W-1:0] py,
                              input logic eoc, input logic flat, input int gap);
        int first_idx;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tdata  <= {py, px};
        s_axis_tlast  <= eoc;
        s_axis_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        first_idx = pending_samples.size();
        predict_point(px, py, eoc);
        if (flat) begin
            for (int i = first_idx; i < pending_samples.size(); i++) begin
                pending_samples[i].x = {2'b00, px};
                pending_samples[i].y = {2'b00, py};
            end
        end
    endtask

    // cycle counter and watchdog
    always @(posedge i_clk)
        cycle_count <= cycle_count + 1;

    initial begin
        cycle_count = 0;
        wait (cycle_count >= TIMEOUT_CYCLES);
        $display("catmull_rom_curve_tessellator verification failed");
        $finish;
    end

    // sample receiver with random stalls, sometimes none for a while
    initial begin
        int n;
        m_axis_tready <= 1'b0;
        no_stall = 1'b0;
        @(posedge i_clk);
        while (!i_rst_n)
            @(posedge i_clk);
        forever begin
            if ($urandom_range(0, 19) == 0)
                no_stall = !no_stall;
            n = no_stall ? 0 : $urandom_range(0, MAX_GAP);
            if (n > 0) begin
                m_axis_tready <= 1'b0;
                repeat (n) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge i_clk);
            while (!(m_axis_tvalid && m_axis_tready))
                @(posedge i_clk);
        end
    end

    // compare each output transaction with the oldest expected sample
    always @(posedge i_clk) begin
        t_sample                 want;
        logic signed [OUT_W-1:0] got_x;
        logic signed [OUT_W-1:0] got_y;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got_x = m_axis_tdata[OUT_W-1:0];
            got_y = m_axis_tdata[2*OUT_W-1:OUT_W];
            if (pending_samples.size() == 0) begin
                flag_error("unexpected sample, x", 0, got_x);
            end else begin
                want = pending_samples.pop_front();
                if (got_x !== want.x)
                    flag_error("sample_x", want.x, got_x);
                if (got_y !== want.y)
                    flag_error("sample_y", want.y, got_y);
                if (m_axis_tuser !== want.pen)
                    flag_error("pen_down", want.pen, m_axis_tuser);
                if (m_axis_tlast !== want.last)
                    flag_error("last_sample", want.last, m_axis_tlast);
            end
        end
    end

    // stimulus
    initial begin
        int                 sent;
        int                 len;
        int                 max_gap;
        t_spread            spread;
        logic [COORD_W-1:0] px;
        logic [COORD_W-1:0] py;

        mismatch_count  = 0;
        points_in_curve = 0;
        sent            = 0;
        for (int i = 0; i < 3; i++) begin
            win_x[i] = '0;
            win_y[i] = '0;
        end
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tlast  <= 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[i])
            send_point(directed_rows[i].x, directed_rows[i].y, directed_rows[i].eoc,
                       directed_rows[i].flat, $urandom_range(0, MAX_GAP));

        // random curves: mostly three points or more, some short ones as noise
        while (sent < RANDOM_ITEMS) begin
            case ($urandom_range(0, 9))
                0: len = 1;
                1: len = 2;
                default: len = $urandom_range(3, 10);
            endcase
            spread  = t_spread'($urandom_range(0, 2));
            max_gap = ($urandom_range(0, 3) == 0) ? 0 : MAX_GAP;
            px      = COORD_W'($urandom);
            py      = COORD_W'($urandom);
            for (int k = 0; k < len; k++) begin
                px = next_coord(spread, px);
                py = next_coord(spread, py);
                send_point(px, py, k == len - 1, 1'b0, $urandom_range(0, max_gap));
                sent++;
            end
        end
        s_axis_tvalid <= 1'b0;

        while (pending_samples.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0 && pending_samples.size() == 0)
            $display("catmull_rom_curve_tessellator verification clean");
        else
            $display("catmull_rom_curve_tessellator verification failed");
        $finish;
    end

endmodule

>>> sim.f
rtl/crt_pkg.sv
rtl/crt_div.sv
rtl/catmull_rom_curve_tessellator.sv
tb/sv/tb.sv
